[design/vrc_pkg.sv]
// vrc_pkg: shared types, codes and the address line remap for the bank mapper
// used by vrc_irq_unit, vrc_rsp_queue and vrc_bank_mapper_with_irq_core
// no dependencies
package vrc_pkg;

   localparam int CHR_SLOTS = 8;

   // request command codes
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   // configuration register indexes
   localparam logic REG_BOARD_VARIANT = 1'b0;
   localparam logic REG_LAST_PRG_BANK = 1'b1;

   // result target codes
   localparam logic [1:0] TGT_NONE   = 2'd0;
   localparam logic [1:0] TGT_PRG    = 2'd1;
   localparam logic [1:0] TGT_CHR    = 2'd2;
   localparam logic [1:0] TGT_MIRROR = 2'd3;

   // board variants
   localparam logic [3:0] BV_VRC2A  = 4'd0;
   localparam logic [3:0] BV_VRC2B  = 4'd1;
   localparam logic [3:0] BV_VRC2C  = 4'd2;
   localparam logic [3:0] BV_VRC4A  = 4'd3;
   localparam logic [3:0] BV_VRC4B  = 4'd4;
   localparam logic [3:0] BV_VRC4C  = 4'd5;
   localparam logic [3:0] BV_VRC4D  = 4'd6;
   localparam logic [3:0] BV_VRC4E  = 4'd7;
   localparam logic [3:0] BV_VRC4F  = 4'd8;
   localparam logic [3:0] BV_LEG23  = 4'd9;
   localparam logic [3:0] BV_LEG25  = 4'd10;
   localparam logic [3:0] BV_LEG21  = 4'd11;

   // address regions after remap (address bits 15:12)
   localparam logic [3:0] RGN_PRG0   = 4'h8;
   localparam logic [3:0] RGN_MODE   = 4'h9;
   localparam logic [3:0] RGN_PRG1   = 4'hA;
   localparam logic [3:0] RGN_CHR0   = 4'hB;
   localparam logic [3:0] RGN_CHR1   = 4'hC;
   localparam logic [3:0] RGN_CHR2   = 4'hD;
   localparam logic [3:0] RGN_CHR3   = 4'hE;
   localparam logic [3:0] RGN_IRQ    = 4'hF;

   // register select within the irq region
   localparam logic [1:0] IRQ_LATCH_LO = 2'd0;
   localparam logic [1:0] IRQ_LATCH_HI = 2'd1;
   localparam logic [1:0] IRQ_CTRL     = 2'd2;
   localparam logic [1:0] IRQ_ACK      = 2'd3;

   typedef struct packed {
      logic        command;
      logic [15:0] address;
      logic [7:0]  data;
   } req_type;

   typedef struct packed {
      logic [1:0] target;
      logic [2:0] window;
      logic [8:0] bank;
      logic       irq_line;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic       tick;
      logic       latch_lo;
      logic       latch_hi;
      logic       ctrl;
      logic       ack;
      logic [7:0] data;
   } irq_ctl_type;

   function automatic logic [1:0] remap_precise(input logic [7:0] a, input logic [7:0] p0,
                                                input logic [7:0] p1, input logic [7:0] p2);
      logic [1:0] r;
      if ((a & p0) == p0) r = 2'd3;
      else if ((a & p1) == p1) r = 2'd2;
      else if ((a & p2) == p2) r = 2'd1;
      else r = 2'd0;
      return r;
   endfunction

   function automatic logic [1:0] remap_legacy(input logic [7:0] a, input logic [7:0] p0a,
                                               input logic [7:0] p0b, input logic [7:0] p1,
                                               input logic [7:0] p2);
      logic [1:0] r;
      if (((a & p0a) == p0a) || ((a & p0b) == p0b)) r = 2'd3;
      else if ((a & p1) != 8'h00) r = 2'd2;
      else if ((a & p2) != 8'h00) r = 2'd1;
      else r = 2'd0;
      return r;
   endfunction

   // register select bits from the board's address line wiring
   function automatic logic [1:0] remap_lo(input logic [3:0] variant, input logic [7:0] a);
      logic [1:0] r;
      case (variant)
         BV_VRC2A, BV_VRC2C, BV_VRC4B: r = remap_precise(a, 8'h03, 8'h01, 8'h02);
         BV_VRC2B, BV_VRC4F:           r = remap_precise(a, 8'h03, 8'h02, 8'h01);
         BV_VRC4A:                     r = remap_precise(a, 8'h06, 8'h04, 8'h02);
         BV_VRC4C:                     r = remap_precise(a, 8'hC0, 8'h80, 8'h40);
         BV_VRC4D:                     r = remap_precise(a, 8'h0C, 8'h04, 8'h08);
         BV_VRC4E:                     r = remap_precise(a, 8'h0C, 8'h08, 8'h04);
         BV_LEG23:                     r = remap_legacy(a, 8'h0C, 8'h03, 8'h0A, 8'h05);
         BV_LEG25:                     r = remap_legacy(a, 8'h0C, 8'h03, 8'h05, 8'h0A);
         default:                      r = remap_legacy(a, 8'h06, 8'hC0, 8'h84, 8'h42);
      endcase
      return r;
   endfunction

endpackage

[design/vrc_irq_unit.sv]
// vrc_irq_unit: irq latch, 8-bit up counter, cycle prescaler and irq line
// depends on vrc_pkg
module vrc_irq_unit #(
   parameter int PRESCALE_PERIOD = 341
) (
   input  logic                 clock,
   input  logic                 reset,
   input  vrc_pkg::irq_ctl_type ctl,
   input  logic                 is_vrc2,
   output logic                 line_in
);
   import vrc_pkg::*;

   localparam int PW = $clog2(PRESCALE_PERIOD + 1) + 1;
   localparam logic signed [PW+1:0] PERIOD_X = (PW+2)'(PRESCALE_PERIOD);
   localparam logic signed [PW+1:0] STEP     = (PW+2)'(3);
   localparam logic signed [PW+1:0] FLOOR    = (PW+2)'(-2);

   logic [7:0]           latch_ff, latch_in;
   logic [7:0]           cnt_ff, cnt_in;
   logic signed [PW-1:0] pre_ff, pre_in;
   logic                 reload_ff, reload_in;
   logic                 enable_ff, enable_in;
   logic                 cycle_ff, cycle_in;
   logic                 ack_ff, ack_in;
   logic                 line_ff;

   logic signed [PW+1:0] pre_x, pre_adj, pre_nxt;
   logic                 clk_en;

   always_comb begin
      latch_in  = latch_ff;
      cnt_in    = cnt_ff;
      pre_in    = pre_ff;
      reload_in = reload_ff;
      enable_in = enable_ff;
      cycle_in  = cycle_ff;
      ack_in    = ack_ff;
      line_in   = line_ff;
      clk_en    = 1'b0;
      pre_x     = (PW+2)'(pre_ff);
      pre_adj   = (pre_x <= 0) ? pre_x + PERIOD_X : pre_x;
      pre_nxt   = pre_adj - STEP;
      // below -2 only happens for tiny periods, where any non-positive value acts the same
      if (pre_nxt < FLOOR) pre_nxt = FLOOR;

      if (ctl.tick && !is_vrc2) begin
         if (ack_ff) begin
            line_in = 1'b0;
            ack_in  = 1'b0;
         end
         clk_en = cycle_ff || (pre_x <= 0);
         pre_in = pre_nxt[PW-1:0];
         if (enable_ff && clk_en) begin
            if (cnt_ff == 8'hFF) begin
               line_in = 1'b1;
               cnt_in  = latch_ff;
            end else begin
               cnt_in = cnt_ff + 8'd1;
            end
         end
      end
      if (ctl.latch_lo) latch_in = {latch_ff[7:4], ctl.data[3:0]};
      if (ctl.latch_hi) latch_in = {ctl.data[3:0], latch_ff[3:0]};
      if (ctl.ctrl) begin
         reload_in = ctl.data[0];
         enable_in = ctl.data[1];
         cycle_in  = ctl.data[2];
         ack_in    = 1'b1;
         if (ctl.data[1]) begin
            cnt_in = latch_ff;
            pre_in = PW'(PRESCALE_PERIOD);
         end
      end
      if (ctl.ack) begin
         ack_in    = 1'b1;
         enable_in = reload_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ff  <= '0;
         cnt_ff    <= '0;
         pre_ff    <= PW'(PRESCALE_PERIOD);
         reload_ff <= 1'b0;
         enable_ff <= 1'b0;
         cycle_ff  <= 1'b0;
         ack_ff    <= 1'b0;
         line_ff   <= 1'b0;
      end else begin
         latch_ff  <= latch_in;
         cnt_ff    <= cnt_in;
         pre_ff    <= pre_in;
         reload_ff <= reload_in;
         enable_ff <= enable_in;
         cycle_ff  <= cycle_in;
         ack_ff    <= ack_in;
         line_ff   <= line_in;
      end
   end

endmodule

[design/vrc_rsp_queue.sv]
// vrc_rsp_queue: two-entry result buffer, takes one or two result words per request
// depends on vrc_pkg
module vrc_rsp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  vrc_pkg::rsp_type first,
   input  vrc_pkg::rsp_type second,
   input  logic             two,
   output logic             busy,
   output logic             rsp_valid,
   output vrc_pkg::rsp_type rsp_word,
   input  logic             rsp_stall
);
   import vrc_pkg::*;

   logic    v0_ff, v0_in, v1_ff, v1_in;
   rsp_type d0_ff, d0_in, d1_ff, d1_in;
   logic    pop;

   assign pop       = v0_ff && !rsp_stall;
   // not busy when no second word waits and the head word is absent or leaves this cycle
   assign busy      = v1_ff || (v0_ff && rsp_stall);
   assign rsp_valid = v0_ff;
   assign rsp_word  = d0_ff;

   always_comb begin
      v0_in = v0_ff;
      v1_in = v1_ff;
      d0_in = d0_ff;
      d1_in = d1_ff;
      if (load) begin
         v0_in = 1'b1;
         d0_in = first;
         v1_in = two;
         d1_in = second;
      end else if (pop) begin
         v0_in = v1_ff;
         d0_in = d1_ff;
         v1_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
      end
   end

   always_ff @(posedge clock) begin
      d0_ff <= d0_in;
      d1_ff <= d1_in;
   end

endmodule

[design/vrc_bank_mapper_with_irq_core.sv]
// vrc_bank_mapper_with_irq_core: bank mapper top level, address decode and bank registers
// depends on vrc_pkg, vrc_irq_unit, vrc_rsp_queue
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  req_word  (command, address, data)
//   rsp_      out        rsp_valid / rsp_stall  rsp_word  (target, window, bank, irq_line, last)
//   csr_      in         csr_valid / csr_ready  csr_index, csr_data
//
// one request word is taken per clock while req_stall is low; its results are ready in the
// output buffer the cycle after. a PRG bank write, or a swap mode write on a non-VRC2 board, gives
// two result words, so req_stall stays high while the second word waits in the buffer.
// reset is synchronous and restores all bank, irq and configuration state at once.
// rsp_stall holds back new requests whenever a result word waits in the output buffer.
module vrc_bank_mapper_with_irq_core #(
   parameter int PRESCALE_PERIOD = 341
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  vrc_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output vrc_pkg::rsp_type rsp_word,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [7:0]       csr_data
);
   import vrc_pkg::*;

   logic [3:0] variant_ff, variant_in;
   logic [7:0] last_prg_ff, last_prg_in;
   logic [4:0] prg_first_ff, prg_first_in;
   logic       swap_ff, swap_in;
   logic [8:0] chr_ff [CHR_SLOTS];
   logic [8:0] chr_in [CHR_SLOTS];

   logic        accept;
   logic        is_vrc2;
   logic [3:0]  hi;
   logic [1:0]  lo;
   logic [3:0]  chr_sub;
   logic [2:0]  slot;
   logic [8:0]  chr_new;
   logic [7:0]  fixed_bank;
   logic        emit_prg;
   logic        line_in;
   irq_ctl_type ctl;
   rsp_type     first, second;
   logic        two;

   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign is_vrc2   = variant_ff <= BV_VRC2C;
   assign hi        = req_word.address[15:12];
   assign lo        = remap_lo(variant_ff, req_word.address[7:0]);
   assign chr_sub   = hi - RGN_CHR0;
   assign slot      = {chr_sub[1:0], lo[1]};
   assign fixed_bank = last_prg_ff - 8'd1;

   always_comb begin
      variant_in   = variant_ff;
      last_prg_in  = last_prg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_BOARD_VARIANT: variant_in  = csr_data[3:0];
            REG_LAST_PRG_BANK: last_prg_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      prg_first_in = prg_first_ff;
      swap_in      = swap_ff;
      chr_in       = chr_ff;
      ctl          = '0;
      ctl.data     = req_word.data;
      first        = '0;
      second       = '0;
      two          = 1'b0;
      emit_prg     = 1'b0;
      chr_new      = chr_ff[slot];
      if (lo[0]) chr_new = {req_word.data[4:0], chr_ff[slot][3:0]};
      else chr_new = {chr_ff[slot][8:4], req_word.data[3:0]};

      if (accept) begin
         if (req_word.command == CMD_TICK) begin
            ctl.tick = 1'b1;
         end else if (req_word.address[15]) begin
            case (hi)
               RGN_PRG0: begin
                  prg_first_in = req_word.data[4:0];
                  emit_prg     = 1'b1;
               end
               RGN_MODE: begin
                  if (lo[1] && !is_vrc2) begin
                     swap_in  = req_word.data[1];
                     emit_prg = 1'b1;
                  end else begin
                     first.target = TGT_MIRROR;
                     first.bank   = {7'd0, req_word.data[1] & !is_vrc2, req_word.data[0]};
                  end
               end
               RGN_PRG1: begin
                  first.target = TGT_PRG;
                  first.window = 3'd1;
                  first.bank   = {4'd0, req_word.data[4:0]};
               end
               RGN_CHR0, RGN_CHR1, RGN_CHR2, RGN_CHR3: begin
                  chr_in[slot] = chr_new;
                  first.target = TGT_CHR;
                  first.window = slot;
                  first.bank   = (variant_ff == BV_VRC2A) ? {1'b0, chr_new[8:1]} : chr_new;
               end
               RGN_IRQ: begin
                  case (lo)
                     IRQ_LATCH_LO: ctl.latch_lo = 1'b1;
                     IRQ_LATCH_HI: ctl.latch_hi = 1'b1;
                     IRQ_CTRL:     ctl.ctrl     = 1'b1;
                     IRQ_ACK:      ctl.ack      = 1'b1;
                     default: ;
                  endcase
               end
               default: ;
            endcase
         end
      end

      // windows 0 and 2 swap between the selected bank and the second-to-last bank
      if (emit_prg) begin
         two           = 1'b1;
         first.target  = TGT_PRG;
         first.window  = 3'd0;
         second.target = TGT_PRG;
         second.window = 3'd2;
         if (swap_in) begin
            first.bank  = {1'b0, fixed_bank};
            second.bank = {4'd0, prg_first_in};
         end else begin
            first.bank  = {4'd0, prg_first_in};
            second.bank = {1'b0, fixed_bank};
         end
      end
      first.irq_line  = line_in;
      second.irq_line = line_in;
      first.last      = !two;
      second.last     = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         variant_ff   <= BV_LEG21;
         last_prg_ff  <= 8'd31;
         prg_first_ff <= '0;
         swap_ff      <= 1'b0;
         for (int i = 0; i < CHR_SLOTS; i++) begin
            chr_ff[i] <= '0;
         end
      end else begin
         variant_ff   <= variant_in;
         last_prg_ff  <= last_prg_in;
         prg_first_ff <= prg_first_in;
         swap_ff      <= swap_in;
         chr_ff       <= chr_in;
      end
   end

   vrc_irq_unit #(
      .PRESCALE_PERIOD(PRESCALE_PERIOD)
   ) u_irq (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .is_vrc2 (is_vrc2),
      .line_in (line_in)
   );

   vrc_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .first     (first),
      .second    (second),
      .two       (two),
      .busy      (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .rsp_stall (rsp_stall)
   );

endmodule

[tb/vrc_bank_mapper_with_irq_core_tb.sv]
// vrc_bank_mapper_with_irq_core_tb: self-checking bench for the bank mapper core
// drives request words and csr writes, predicts the result words and compares them
// depends on vrc_pkg and vrc_bank_mapper_with_irq_core
`timescale 1ns / 1ps

module vrc_bank_mapper_with_irq_core_tb;
   import vrc_pkg::*;

   localparam int PRESCALE = 341;
   localparam logic [2:0] WIN_LOW  = 3'd0;
   localparam logic [2:0] WIN_MID  = 3'd1;
   localparam logic [2:0] WIN_HIGH = 3'd2;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_word = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_word;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_index = REG_BOARD_VARIANT;
   logic [7:0] csr_data = 8'd0;

   vrc_bank_mapper_with_irq_core #(
      .PRESCALE_PERIOD(PRESCALE)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // predicted mapper state, starts at its reset values
   logic [3:0] cfg_variant = BV_LEG21;
   logic [7:0] cfg_prg_top = 8'd31;
   logic [4:0] prg_bank_r = '0;
   logic       prg_swap_r = 1'b0;
   logic [8:0] chr_r [CHR_SLOTS];
   logic [7:0] latch_r = '0;
   logic [7:0] count_r = '0;
   int         presc_r = PRESCALE;
   logic       fl_reload = 1'b0;
   logic       fl_enable = 1'b0;
   logic       fl_cycle = 1'b0;
   logic       fl_ack = 1'b0;
   logic       fl_line = 1'b0;

   req_type pending_reqs [$];
   rsp_type mapping_due [$];
   int      queued = 0;
   int      words_sent = 0;
   int      words_checked = 0;
   int      irq_seen = 0;
   int      errors = 0;
   bit      quiet = 1'b0;
   int      gap_left = 0;
   int      stall_left = 0;
   int      hold_left = 0;
   bit      hold_done = 1'b0;

   initial begin
      for (int k = 0; k < CHR_SLOTS; k++) chr_r[k] = '0;
   end

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // returns {region, register select} after the board's address line wiring
   function automatic logic [5:0] bus_address(input logic [15:0] a);
      logic [7:0] m0, m0b, m1, m2;
      logic       loose;
      logic [1:0] sel;
      loose = 1'b0;
      m0b = 8'h00;
      case (cfg_variant)
         BV_VRC2A, BV_VRC2C, BV_VRC4B: {m0, m1, m2} = {8'h03, 8'h01, 8'h02};
         BV_VRC2B, BV_VRC4F:           {m0, m1, m2} = {8'h03, 8'h02, 8'h01};
         BV_VRC4A:                     {m0, m1, m2} = {8'h06, 8'h04, 8'h02};
         BV_VRC4C:                     {m0, m1, m2} = {8'hC0, 8'h80, 8'h40};
         BV_VRC4D:                     {m0, m1, m2} = {8'h0C, 8'h04, 8'h08};
         BV_VRC4E:                     {m0, m1, m2} = {8'h0C, 8'h08, 8'h04};
         BV_LEG23: begin
            {m0, m0b, m1, m2} = {8'h0C, 8'h03, 8'h0A, 8'h05};
            loose = 1'b1;
         end
         BV_LEG25: begin
            {m0, m0b, m1, m2} = {8'h0C, 8'h03, 8'h05, 8'h0A};
            loose = 1'b1;
         end
         default: begin
            // undefined variants fall back to the mapper 21 wiring
            {m0, m0b, m1, m2} = {8'h06, 8'hC0, 8'h84, 8'h42};
            loose = 1'b1;
         end
      endcase
      if ((a[7:0] & m0) == m0 || (loose && (a[7:0] & m0b) == m0b)) sel = 2'd3;
      else if (loose ? (a[7:0] & m1) != 8'h00 : (a[7:0] & m1) == m1) sel = 2'd2;
      else if (loose ? (a[7:0] & m2) != 8'h00 : (a[7:0] & m2) == m2) sel = 2'd1;
      else sel = 2'd0;
      return {a[15:12], sel};
   endfunction

   function automatic rsp_type map_word(input logic [1:0] tgt, input logic [2:0] win,
                                        input logic [8:0] bank);
      rsp_type w;
      w.target = tgt;
      w.window = win;
      w.bank = bank;
      w.irq_line = fl_line;
      w.last = 1'b0;
      return w;
   endfunction

   function automatic void step_irq();
      logic pulse;
      if (cfg_variant <= BV_VRC2C) return;
      if (fl_ack) begin
         fl_line = 1'b0;
         fl_ack = 1'b0;
      end
      pulse = fl_cycle;
      if (presc_r <= 0) begin
         if (!fl_cycle) pulse = 1'b1;
         presc_r += PRESCALE;
      end
      presc_r -= 3;
      if (fl_enable && pulse) begin
         if (count_r == 8'hFF) begin
            fl_line = 1'b1;
            count_r = latch_r;
         end else begin
            count_r = count_r + 8'd1;
         end
      end
   endfunction

   // updates the predicted state for one accepted request and queues its result words
   function automatic void apply_request(input req_type w);
      rsp_type    r [2];
      int         n;
      logic [5:0] bus;
      logic [3:0] off;
      logic [2:0] slot;
      logic [8:0] b;
      logic [7:0] tail_bank;
      logic [1:0] tgt;
      logic [2:0] win;
      n = 1;
      tgt = TGT_NONE;
      win = 3'd0;
      b = 9'd0;
      if (w.command == CMD_TICK) begin
         step_irq();
      end else if (w.address[15]) begin
         bus = bus_address(w.address);
         case (bus[5:2])
            RGN_PRG0: begin
               prg_bank_r = w.data[4:0];
               n = 2;
            end
            RGN_MODE: begin
               if (bus[1] && cfg_variant > BV_VRC2C) begin
                  prg_swap_r = w.data[1];
                  n = 2;
               end else begin
                  // vrc2 has only the one mirroring bit, and 9002/9003 alias it
                  tgt = TGT_MIRROR;
                  b = (cfg_variant <= BV_VRC2C) ? {8'd0, w.data[0]} : {7'd0, w.data[1:0]};
               end
            end
            RGN_PRG1: begin
               tgt = TGT_PRG;
               win = WIN_MID;
               b = {4'd0, w.data[4:0]};
            end
            RGN_CHR0, RGN_CHR1, RGN_CHR2, RGN_CHR3: begin
               off = bus[5:2] - RGN_CHR0;
               slot = {off[1:0], bus[1]};
               if (!bus[0]) chr_r[slot][3:0] = w.data[3:0];
               else chr_r[slot][8:4] = w.data[4:0];
               b = chr_r[slot];
               if (cfg_variant == BV_VRC2A) b = b >> 1;
               tgt = TGT_CHR;
               win = slot;
            end
            RGN_IRQ: begin
               case (bus[1:0])
                  IRQ_LATCH_LO: latch_r[3:0] = w.data[3:0];
                  IRQ_LATCH_HI: latch_r[7:4] = w.data[3:0];
                  IRQ_CTRL: begin
                     fl_reload = w.data[0];
                     fl_enable = w.data[1];
                     fl_cycle = w.data[2];
                     if (fl_enable) begin
                        count_r = latch_r;
                        presc_r = PRESCALE;
                     end
                     fl_ack = 1'b1;
                  end
                  default: begin
                     fl_ack = 1'b1;
                     fl_enable = fl_reload;
                  end
               endcase
            end
            default: ;
         endcase
      end
      if (n == 2) begin
         tail_bank = cfg_prg_top - 8'd1;
         r[0] = map_word(TGT_PRG, WIN_LOW, prg_swap_r ? {1'b0, tail_bank} : {4'd0, prg_bank_r});
         r[1] = map_word(TGT_PRG, WIN_HIGH, prg_swap_r ? {4'd0, prg_bank_r} : {1'b0, tail_bank});
      end else begin
         r[0] = map_word(tgt, win, b);
      end
      r[n-1].last = 1'b1;
      for (int k = 0; k < n; k++) mapping_due.push_back(r[k]);
   endfunction

   // sender: one request word per handshake, with random idle bursts between words
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            apply_request(req_word);
            words_sent <= words_sent + 1;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
               gap_left <= $urandom_range(0, 3);
               req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               req_word <= pending_reqs.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall: random bursts plus one long hold that backs the core up
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && words_sent >= 300 && pending_reqs.size() >= 8) begin
         hold_done <= 1'b1;
         hold_left <= 80;
         rsp_stall <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 3);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         errors++;
         if (errors <= 40)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         words_checked++;
         if (rsp_word.irq_line) irq_seen++;
         if (mapping_due.size() == 0) begin
            errors++;
            if (errors <= 40)
               $display("%0t: result word with nothing pending, expected none, actual %h",
                        $time, rsp_word);
         end else begin
            want = mapping_due.pop_front();
            check_field("target", int'(want.target), int'(rsp_word.target));
            check_field("window", int'(want.window), int'(rsp_word.window));
            check_field("bank", int'(want.bank), int'(rsp_word.bank));
            check_field("irq_line", int'(want.irq_line), int'(rsp_word.irq_line));
            check_field("last", int'(want.last), int'(rsp_word.last));
         end
      end
   end

   function automatic void push_item(input logic cmd, input logic [15:0] addr,
                                     input logic [7:0] data);
      req_type w;
      w.command = cmd;
      w.address = addr;
      w.data = data;
      pending_reqs.push_back(w);
      queued++;
   endfunction

   // random address whose wiring lands on the wanted region and register select
   function automatic logic [15:0] pick_addr(input logic [3:0] region, input logic [1:0] sel);
      logic [15:0] a;
      logic [5:0]  bus;
      for (int k = 0; k < 200; k++) begin
         a = 16'($urandom);
         a[15:12] = region;
         bus = bus_address(a);
         if (bus[1:0] == sel) return a;
      end
      return a;
   endfunction

   task automatic write_reg(input logic idx, input logic [7:0] value);
      @(posedge clock);
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_BOARD_VARIANT) cfg_variant = value[3:0];
      else cfg_prg_top = value;
   endtask

   // checked away from the rising edge so the sender's updates have settled
   task automatic wait_drained();
      @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || mapping_due.size() != 0)
         @(negedge clock);
   endtask

   task automatic random_phase(input int count);
      int         stop;
      int         pick;
      int         ticks;
      logic [7:0] d;
      stop = queued + count;
      while (queued < stop) begin
         pick = $urandom_range(0, 9);
         if (pick <= 2) begin
            push_item(CMD_TICK, 16'($urandom), 8'($urandom));
         end else if (pick == 3) begin
            push_item(CMD_WRITE, 16'($urandom_range(0, 16'h7FFF)), 8'($urandom));
         end else if (pick <= 7) begin
            push_item(CMD_WRITE, 16'h8000 | 16'($urandom_range(0, 16'h7FFF)), 8'($urandom));
         end else begin
            // irq setup with a latch near the top so the counter wraps soon
            push_item(CMD_WRITE, pick_addr(RGN_IRQ, IRQ_LATCH_LO), 8'($urandom));
            d = 8'($urandom);
            d[3:0] = 4'hF;
            push_item(CMD_WRITE, pick_addr(RGN_IRQ, IRQ_LATCH_HI), d);
            d = 8'($urandom);
            if ($urandom_range(0, 3) != 0) d[1] = 1'b1;
            push_item(CMD_WRITE, pick_addr(RGN_IRQ, IRQ_CTRL), d);
            ticks = $urandom_range(4, 24);
            repeat (ticks) push_item(CMD_TICK, 16'($urandom), 8'($urandom));
            if ($urandom_range(0, 2) != 0)
               push_item(CMD_WRITE, pick_addr(RGN_IRQ, IRQ_ACK), 8'($urandom));
         end
      end
   endtask

   initial begin
      logic [7:0] cv;
      logic [7:0] prg_top;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed words under the reset wiring (mapper 21 layout)
      push_item(CMD_TICK, 16'hFFFF, 8'hFF);
      push_item(CMD_WRITE, 16'h0000, 8'h00);
      push_item(CMD_WRITE, 16'h7FFF, 8'hFF);
      push_item(CMD_WRITE, 16'h8000, 8'hFF);
      push_item(CMD_WRITE, 16'h9006, 8'h02);
      push_item(CMD_WRITE, 16'h8000, 8'h00);
      push_item(CMD_WRITE, 16'h9004, 8'h00);
      push_item(CMD_WRITE, 16'h9000, 8'h03);
      push_item(CMD_WRITE, 16'hA000, 8'hFF);
      push_item(CMD_WRITE, 16'hB000, 8'hFF);
      push_item(CMD_WRITE, 16'hB002, 8'hFF);
      push_item(CMD_WRITE, 16'hE006, 8'hAA);
      push_item(CMD_WRITE, 16'hE004, 8'h55);
      push_item(CMD_WRITE, 16'hF000, 8'h0E);
      push_item(CMD_WRITE, 16'hF002, 8'h0F);
      push_item(CMD_WRITE, 16'hF004, 8'h07);
      repeat (3) push_item(CMD_TICK, 16'h0000, 8'h00);
      push_item(CMD_WRITE, 16'hF004, 8'h06);
      repeat (2) push_item(CMD_TICK, 16'h0000, 8'h00);
      // acknowledge with reload clear: line falls on the next tick, counting stops
      push_item(CMD_WRITE, 16'hF006, 8'h00);
      push_item(CMD_TICK, 16'h0000, 8'h00);
      push_item(CMD_WRITE, 16'hFFFF, 8'hFF);
      wait_drained();

      for (int v = 0; v < 16; v++) begin
         if (v == 15) quiet = 1'b1;
         cv = 8'($urandom);
         cv[3:0] = v[3:0];
         case (v)
            0: prg_top = 8'd0;
            1: prg_top = 8'd1;
            2: prg_top = 8'd255;
            3: prg_top = 8'd31;
            default: prg_top = 8'($urandom_range(1, 255));
         endcase
         write_reg(REG_BOARD_VARIANT, cv);
         write_reg(REG_LAST_PRG_BANK, prg_top);
         random_phase(42);
         wait_drained();
      end

      repeat (5) @(posedge clock);
      if (mapping_due.size() != 0) begin
         errors += mapping_due.size();
         $display("%0t: result words missing, expected %0d more, actual 0",
                  $time, mapping_due.size());
      end
      $display("sent %0d request words across all 16 board variants and both count modes",
               words_sent);
      $display("compared %0d result words, %0d of them with the irq line high",
               words_checked, irq_seen);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

[filelist.f]
design/vrc_pkg.sv
design/vrc_irq_unit.sv
design/vrc_rsp_queue.sv
design/vrc_bank_mapper_with_irq_core.sv
tb/vrc_bank_mapper_with_irq_core_tb.sv
